FILE: rtl/fcwm_pkg.sv
// Shared constants, codes and transaction types of the four-character word machine.
`timescale 1ns / 1ps
package fcwm_pkg;

  // Machine size.
  localparam int MEM_WORDS   = 100;
  localparam int BLOCK_WORDS = 10;
  localparam int ADDR_W      = 7;
  localparam int WORD_W      = 32;
  localparam int MEM_AW      = $clog2(MEM_WORDS);
  localparam int CNT_W       = $clog2(BLOCK_WORDS + 1);

  localparam logic [WORD_W-1:0] SPACE_WORD = 32'h2020_2020;

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_EXEC = 2'd1;
  localparam logic [1:0] OP_DATA = 2'd2;

  // Status codes of a result transaction.
  localparam logic [2:0] ST_DONE   = 3'd0;
  localparam logic [2:0] ST_AWAIT  = 3'd1;
  localparam logic [2:0] ST_OUTPUT = 3'd2;
  localparam logic [2:0] ST_HALTED = 3'd3;
  localparam logic [2:0] ST_ADDR   = 3'd4;
  localparam logic [2:0] ST_REJECT = 3'd5;

  // Characters used by the instruction decoder.
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Input transaction.
  typedef struct packed {
    logic [1:0]        operation;
    logic [ADDR_W-1:0] address;
    logic [WORD_W-1:0] word;
    logic [2:0]        valid_chars;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic [2:0]        status;
    logic [WORD_W-1:0] out_word;
    logic              last;
    logic [ADDR_W-1:0] program_counter;
    logic              compare_flag;
  } out_item_t;

endpackage

FILE: rtl/four_char_word_machine_step.sv
// Top level of the four-character word machine: sequencer around one word memory.
`timescale 1ns / 1ps
// Usage:
//   Input channel: drive in_item and raise start; the transaction is taken at
//   a rising edge where start is high and busy is low. operation selects a
//   memory load, one instruction step, or one data word for a pending GD.
//   Result channel: every result shows on out_res for one cycle with
//   out_valid high. The receiver cannot stall; it must take every result.
//   Timing: a load, a data word that does not end a GD block early, and any
//   rejected or refused step give their result in the next cycle and leave
//   busy low, so one such transaction per cycle is taken. An executed step
//   passes through fetch and decode; LR and CR add an operand read. PD
//   results follow back to back after decode, BLOCK_WORDS of them. A data
//   word that ends a GD block early keeps busy high while the rest of the
//   block is filled with spaces. All of this is set by the single read and
//   single write port of the word memory, used one access at a time.
//   Reset: rst_n is synchronous and active low. All control state clears and
//   a per-word valid bit makes every memory word read as four spaces until
//   it is written, so no clearing pass is needed.
module four_char_word_machine_step_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fcwm_pkg::in_item_t  in_item,
  output logic                out_valid,
  output fcwm_pkg::out_item_t out_res
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_FETCH  = 6'b000010,
    S_DECODE = 6'b000100,
    S_OPRD   = 6'b001000,
    S_PD     = 6'b010000,
    S_FILL   = 6'b100000
  } state_t;

  localparam logic [fcwm_pkg::ADDR_W-1:0] MEM_LIMIT =
    fcwm_pkg::ADDR_W'(fcwm_pkg::MEM_WORDS);
  localparam logic [fcwm_pkg::ADDR_W:0] BLOCK_LIMIT =
    (fcwm_pkg::ADDR_W + 1)'(fcwm_pkg::MEM_WORDS - fcwm_pkg::BLOCK_WORDS);
  localparam logic [fcwm_pkg::CNT_W-1:0] BLOCK_CNT =
    fcwm_pkg::CNT_W'(fcwm_pkg::BLOCK_WORDS);
  localparam logic [fcwm_pkg::CNT_W-1:0] BLOCK_LAST =
    fcwm_pkg::CNT_W'(fcwm_pkg::BLOCK_WORDS - 1);

  // Architectural and control registers.
  state_t                        state_r, state_nxt;
  logic [fcwm_pkg::WORD_W-1:0]   ir_r, ir_nxt;
  logic [fcwm_pkg::WORD_W-1:0]   gr_r, gr_nxt;
  logic                          flag_r, flag_nxt;
  logic [fcwm_pkg::ADDR_W-1:0]   pc_r, pc_nxt;
  logic                          halted_r, halted_nxt;
  logic                          pend_r, pend_nxt;
  logic [fcwm_pkg::ADDR_W-1:0]   tgt_r, tgt_nxt;
  logic [fcwm_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          ended_r, ended_nxt;
  logic [fcwm_pkg::ADDR_W-1:0]   opaddr_r, opaddr_nxt;
  logic [fcwm_pkg::CNT_W-1:0]    pdcnt_r, pdcnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  fcwm_pkg::out_item_t           out_res_r, out_res_nxt;
  logic [fcwm_pkg::MEM_WORDS-1:0] vld_r;
  logic                          rd_vld_r;

  // Memory port signals.
  logic                          mem_we;
  logic [fcwm_pkg::ADDR_W-1:0]   mem_waddr;
  logic [fcwm_pkg::WORD_W-1:0]   mem_wdata;
  logic [fcwm_pkg::ADDR_W-1:0]   mem_raddr;
  logic [fcwm_pkg::WORD_W-1:0]   ram_q;
  logic [fcwm_pkg::WORD_W-1:0]   mem_rd;

  // Result being formed this cycle.
  logic [2:0]                    res_status;
  logic [fcwm_pkg::WORD_W-1:0]   res_word;
  logic                          res_last;

  // Instruction decode.
  logic [7:0]                    c0, c1, c2, c3;
  logic                          is_gd, is_pd, is_h, is_lr, is_sr, is_cr, is_bt;
  logic                          digits_ok;
  logic [fcwm_pkg::ADDR_W-1:0]   dec_addr;
  logic                          block_ok, word_ok;

  // Data word packing for GD.
  logic [2:0]                    vc;
  logic                          ended_acc;
  logic [fcwm_pkg::WORD_W-1:0]   data_word;
  logic [7:0]                    ch;
  logic [fcwm_pkg::ADDR_W-1:0]   fill_addr;
  logic [fcwm_pkg::CNT_W-1:0]    cnt_inc;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Word memory; unwritten words read as spaces through the valid bits.
  fcwm_ram #(
    .WIDTH (fcwm_pkg::WORD_W),
    .DEPTH (fcwm_pkg::MEM_WORDS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr[fcwm_pkg::MEM_AW-1:0]),
    .wdata (mem_wdata),
    .raddr (mem_raddr[fcwm_pkg::MEM_AW-1:0]),
    .rdata (ram_q)
  );

  assign mem_rd = rd_vld_r ? ram_q : fcwm_pkg::SPACE_WORD;

  // Decode the held instruction word.
  always_comb begin
    c0 = ir_r[31:24];
    c1 = ir_r[23:16];
    c2 = ir_r[15:8];
    c3 = ir_r[7:0];
    is_gd = (c0 == fcwm_pkg::CH_G) && (c1 == fcwm_pkg::CH_D);
    is_pd = !is_gd && (c0 == fcwm_pkg::CH_P) && (c1 == fcwm_pkg::CH_D);
    is_h  = (c0 == fcwm_pkg::CH_H);
    is_lr = (c0 == fcwm_pkg::CH_L) && (c1 == fcwm_pkg::CH_R);
    is_sr = (c0 == fcwm_pkg::CH_S) && (c1 == fcwm_pkg::CH_R);
    is_cr = (c0 == fcwm_pkg::CH_C) && (c1 == fcwm_pkg::CH_R);
    is_bt = (c0 == fcwm_pkg::CH_B) && (c1 == fcwm_pkg::CH_T);
    digits_ok = (c2 >= fcwm_pkg::CH_ZERO) && (c2 <= fcwm_pkg::CH_NINE) &&
                (c3 >= fcwm_pkg::CH_ZERO) && (c3 <= fcwm_pkg::CH_NINE);
    dec_addr = fcwm_pkg::ADDR_W'(c2[3:0]) * fcwm_pkg::ADDR_W'(10) +
               fcwm_pkg::ADDR_W'(c3[3:0]);
    block_ok = ({1'b0, dec_addr} <= BLOCK_LIMIT);
    word_ok  = (dec_addr < MEM_LIMIT);
  end

  // Pack a supplied data word: the first missing character ends the data.
  always_comb begin
    vc = (in_item.valid_chars > 3'd4) ? 3'd4 : in_item.valid_chars;
    ended_acc = ended_r;
    data_word = '0;
    ch = '0;
    for (int pos = 0; pos < 4; pos++) begin
      ch = in_item.word[(3 - pos) * 8 +: 8];
      if (ended_acc || (3'(pos) >= vc) || (ch == 8'h00)) begin
        ended_acc = 1'b1;
        ch = fcwm_pkg::CH_SPACE;
      end
      data_word[(3 - pos) * 8 +: 8] = ch;
    end
    fill_addr = tgt_r + fcwm_pkg::ADDR_W'(cnt_r);
    cnt_inc   = cnt_r + 1'b1;
  end

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    ir_nxt     = ir_r;
    gr_nxt     = gr_r;
    flag_nxt   = flag_r;
    pc_nxt     = pc_r;
    halted_nxt = halted_r;
    pend_nxt   = pend_r;
    tgt_nxt    = tgt_r;
    cnt_nxt    = cnt_r;
    ended_nxt  = ended_r;
    opaddr_nxt = opaddr_r;
    pdcnt_nxt  = pdcnt_r;
    mem_we     = 1'b0;
    mem_waddr  = fill_addr;
    mem_wdata  = fcwm_pkg::SPACE_WORD;
    mem_raddr  = pc_r;
    out_valid_nxt = 1'b0;
    res_status = fcwm_pkg::ST_DONE;
    res_word   = '0;
    res_last   = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          out_valid_nxt = 1'b1;
          case (in_item.operation)
            fcwm_pkg::OP_LOAD: begin
              if (in_item.address < MEM_LIMIT) begin
                mem_we    = 1'b1;
                mem_waddr = in_item.address;
                mem_wdata = in_item.word;
              end else begin
                res_status = fcwm_pkg::ST_REJECT;
              end
            end
            fcwm_pkg::OP_EXEC: begin
              if (halted_r) begin
                res_status = fcwm_pkg::ST_HALTED;
              end else if (pend_r) begin
                res_status = fcwm_pkg::ST_REJECT;
              end else if (pc_r >= MEM_LIMIT) begin
                res_status = fcwm_pkg::ST_ADDR;
              end else begin
                out_valid_nxt = 1'b0;
                mem_raddr     = pc_r;
                state_nxt     = S_FETCH;
              end
            end
            fcwm_pkg::OP_DATA: begin
              if (!pend_r) begin
                res_status = fcwm_pkg::ST_REJECT;
              end else begin
                mem_we    = 1'b1;
                mem_wdata = data_word;
                cnt_nxt   = cnt_inc;
                ended_nxt = ended_acc;
                if (cnt_inc >= BLOCK_CNT) begin
                  pend_nxt = 1'b0;
                end else if (ended_acc) begin
                  out_valid_nxt = 1'b0;
                  state_nxt     = S_FILL;
                end else begin
                  res_status = fcwm_pkg::ST_AWAIT;
                end
              end
            end
            default: begin
              res_status = fcwm_pkg::ST_REJECT;
            end
          endcase
        end
      end
      S_FETCH: begin
        ir_nxt    = mem_rd;
        pc_nxt    = pc_r + 1'b1;
        state_nxt = S_DECODE;
      end
      S_DECODE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (is_h) begin
          halted_nxt = 1'b1;
          res_status = fcwm_pkg::ST_HALTED;
        end else if (!(is_gd || is_pd || is_lr || is_sr || is_cr || is_bt)) begin
          res_status = fcwm_pkg::ST_DONE;
        end else if (!digits_ok) begin
          res_status = fcwm_pkg::ST_ADDR;
        end else if ((is_gd || is_pd) ? !block_ok : !word_ok) begin
          res_status = fcwm_pkg::ST_ADDR;
        end else if (is_gd) begin
          pend_nxt   = 1'b1;
          tgt_nxt    = dec_addr;
          cnt_nxt    = '0;
          ended_nxt  = 1'b0;
          res_status = fcwm_pkg::ST_AWAIT;
        end else if (is_pd) begin
          out_valid_nxt = 1'b0;
          mem_raddr     = dec_addr;
          opaddr_nxt    = dec_addr;
          pdcnt_nxt     = '0;
          state_nxt     = S_PD;
        end else if (is_lr || is_cr) begin
          out_valid_nxt = 1'b0;
          mem_raddr     = dec_addr;
          state_nxt     = S_OPRD;
        end else if (is_sr) begin
          mem_we    = 1'b1;
          mem_waddr = dec_addr;
          mem_wdata = gr_r;
        end else begin
          if (flag_r) begin
            pc_nxt = dec_addr;
          end
        end
      end
      S_OPRD: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (is_lr) begin
          gr_nxt = mem_rd;
        end else begin
          flag_nxt = (gr_r == mem_rd);
        end
      end
      S_PD: begin
        out_valid_nxt = 1'b1;
        res_status    = fcwm_pkg::ST_OUTPUT;
        res_word      = mem_rd;
        res_last      = (pdcnt_r == BLOCK_LAST);
        if (pdcnt_r == BLOCK_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          pdcnt_nxt = pdcnt_r + 1'b1;
          mem_raddr = opaddr_r + fcwm_pkg::ADDR_W'(pdcnt_r) + 1'b1;
        end
      end
      S_FILL: begin
        mem_we  = 1'b1;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= BLOCK_CNT) begin
          pend_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_res_nxt.status          = res_status;
    out_res_nxt.out_word        = res_word;
    out_res_nxt.last            = res_last;
    out_res_nxt.program_counter = pc_nxt;
    out_res_nxt.compare_flag    = flag_nxt;
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ir_r        <= '0;
      gr_r        <= '0;
      flag_r      <= 1'b0;
      pc_r        <= '0;
      halted_r    <= 1'b0;
      pend_r      <= 1'b0;
      tgt_r       <= '0;
      cnt_r       <= '0;
      ended_r     <= 1'b0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      ir_r        <= ir_nxt;
      gr_r        <= gr_nxt;
      flag_r      <= flag_nxt;
      pc_r        <= pc_nxt;
      halted_r    <= halted_nxt;
      pend_r      <= pend_nxt;
      tgt_r       <= tgt_nxt;
      cnt_r       <= cnt_nxt;
      ended_r     <= ended_nxt;
      out_valid_r <= out_valid_nxt;
      if (mem_we) begin
        vld_r[mem_waddr[fcwm_pkg::MEM_AW-1:0]] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    opaddr_r <= opaddr_nxt;
    pdcnt_r  <= pdcnt_nxt;
    rd_vld_r <= vld_r[mem_raddr[fcwm_pkg::MEM_AW-1:0]];
    if (out_valid_nxt) begin
      out_res_r <= out_res_nxt;
    end
  end

endmodule

FILE: rtl/fcwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fcwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
